// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted (active-low reset).
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/utf8u_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8u_pkg
// Shared types and constants for the UTF-8 to UCS-2 stream decoder.
// ----------------------------------------------------------------------------
package utf8u_pkg;

    localparam int BYTE_W     = 8;
    localparam int UNIT_W     = 16;
    localparam int TOTAL_W    = 17;
    localparam int CAP_W      = 16;
    localparam int LEFT_W     = 3;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Lead byte thresholds (legacy 1..6 byte form)
    localparam logic [BYTE_W-1:0] LEAD6 = 8'hFC;
    localparam logic [BYTE_W-1:0] LEAD5 = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4 = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3 = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2 = 8'hC0;

    // Register index of capacity (byte address 4 * index)
    localparam logic REG_CAPACITY = 1'b0;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_UNIT = 2'd0,
        KIND_END  = 2'd1,
        KIND_FULL = 2'd2
    } t_kind;

    // Result of one decode step
    typedef struct packed {
        logic                has;
        t_kind               kind;
        logic [UNIT_W-1:0]   code;
        logic [TOTAL_W-1:0]  total;
    } t_result;

endpackage

// ===== sv/utf8u_byte_if.sv =====
// ----------------------------------------------------------------------------
// utf8u_byte_if
// Byte channel: one UTF-8 byte per transaction.
// ----------------------------------------------------------------------------
interface utf8u_byte_if import utf8u_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== sv/utf8u_unit_if.sv =====
// ----------------------------------------------------------------------------
// utf8u_unit_if
// Result channel: code unit, end-of-string or capacity-reached report.
// ----------------------------------------------------------------------------
interface utf8u_unit_if import utf8u_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [UNIT_W-1:0]  code_unit;
    logic [TOTAL_W-1:0] total;

    modport source (output valid, output kind, output code_unit, output total, input ready);
    modport sink   (input valid, input kind, input code_unit, input total, output ready);
endinterface

// ===== sv/utf8_to_ucs2_stream_top.sv =====
// ----------------------------------------------------------------------------
// utf8_to_ucs2_stream_top
// Decodes a NUL-terminated UTF-8 byte stream (legacy 1..6 byte form) into
// UCS-2 code units, with capacity limit and a count-only sizing mode.
// ----------------------------------------------------------------------------
// One byte is accepted per clock while no result waits on a stalled result
// register. An accepted byte is held in the input register while the decoder
// step runs. Its result, if any, is loaded into the result register when the
// step is taken and is offered on the result channel from then on. The decoder
// state (partial code, bytes left, unit count, discard flag) is updated in the
// same cycle as the step, so bytes can follow back to back. A byte that yields
// no result is consumed even while the result register is stalled; a byte that
// yields a result waits for the result register.
// Capacity (byte address 0) may be written only while the block is idle.
module utf8_to_ucs2_stream_top import utf8u_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    utf8u_byte_if.sink            i_byte,
    utf8u_unit_if.source          o_res
);

    logic [CAP_W-1:0]  capacity;
    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              fire;
    t_result           result;

    utf8u_apb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    utf8u_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_fire  (fire),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    utf8u_decode u_dec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (in_byte),
        .i_fire     (fire),
        .i_capacity (capacity),
        .o_result   (result)
    );

    utf8u_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_valid),
        .i_result (result),
        .o_fire   (fire),
        .o_res    (o_res)
    );

endmodule

// ===== sv/utf8u_apb_cfg.sv =====
// ----------------------------------------------------------------------------
// utf8u_apb_cfg
// APB register slave holding the capacity register.
// ----------------------------------------------------------------------------
module utf8u_apb_cfg import utf8u_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CAP_W-1:0]      o_capacity
);

    logic [CAP_W-1:0] r_capacity;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
        end else if (wr_en) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY) begin
            prdata = {{(APB_DATA_W-CAP_W){1'b0}}, r_capacity};
        end
    end

    assign o_capacity = r_capacity;

endmodule

// ===== sv/utf8u_in_stage.sv =====
// ----------------------------------------------------------------------------
// utf8u_in_stage
// Input register: captures one byte per transaction.
// ----------------------------------------------------------------------------
module utf8u_in_stage import utf8u_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    utf8u_byte_if.sink        i_byte,
    input  logic              i_fire,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    // take a new byte when empty or when the held one is consumed
    assign i_byte.ready = !r_valid || i_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_valid <= 1'b1;
            r_byte  <= i_byte.in_byte;
        end else if (i_fire) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== sv/utf8u_decode.sv =====
// ----------------------------------------------------------------------------
// utf8u_decode
// Decoder state and per-byte step logic: lead/continuation handling,
// unit counting, capacity check and end-of-string report.
// ----------------------------------------------------------------------------
module utf8u_decode import utf8u_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_fire,
    input  logic [CAP_W-1:0]  i_capacity,
    output t_result           o_result
);

    // only the low 16 code bits ever reach the output
    logic [UNIT_W-1:0] r_partial, n_partial;
    logic [LEFT_W-1:0] r_left,    n_left;
    logic [CAP_W-1:0]  r_count,   n_count;
    logic              r_discard, n_discard;

    logic              finish;
    logic [UNIT_W-1:0] finish_code;
    logic              sizing;
    t_result           res;

    assign sizing = (i_capacity == '0);

    // one step of the decoder
    always_comb begin
        n_partial   = r_partial;
        n_left      = r_left;
        n_count     = r_count;
        n_discard   = r_discard;
        finish      = 1'b0;
        finish_code = '0;
        res         = '{has: 1'b0, kind: KIND_UNIT, code: '0, total: '0};

        if (i_byte == '0) begin
            // end of string
            if (!r_discard) begin
                res.has   = 1'b1;
                res.kind  = KIND_END;
                res.total = sizing ? {r_count, 1'b0} : {1'b0, r_count};
            end
            n_partial = '0;
            n_left    = '0;
            n_count   = '0;
            n_discard = 1'b0;
        end else if (r_discard) begin
            // drop until NUL
        end else if (r_left != '0) begin
            // continuation byte, not checked
            n_partial = {r_partial[UNIT_W-7:0], i_byte[5:0]};
            n_left    = r_left - 1'b1;
            if (r_left == LEFT_W'(1)) begin
                finish      = 1'b1;
                finish_code = {r_partial[UNIT_W-7:0], i_byte[5:0]};
            end
        end else if (!sizing && (r_count >= i_capacity)) begin
            // capacity reached at the first byte of a character
            n_discard = 1'b1;
            res.has   = 1'b1;
            res.kind  = KIND_FULL;
            res.total = {1'b0, r_count};
        end else if (i_byte >= LEAD6) begin
            n_partial = {15'b0, i_byte[0]};
            n_left    = LEFT_W'(5);
        end else if (i_byte >= LEAD5) begin
            n_partial = {14'b0, i_byte[1:0]};
            n_left    = LEFT_W'(4);
        end else if (i_byte >= LEAD4) begin
            n_partial = {13'b0, i_byte[2:0]};
            n_left    = LEFT_W'(3);
        end else if (i_byte >= LEAD3) begin
            n_partial = {12'b0, i_byte[3:0]};
            n_left    = LEFT_W'(2);
        end else if (i_byte >= LEAD2) begin
            n_partial = {11'b0, i_byte[4:0]};
            n_left    = LEFT_W'(1);
        end else begin
            // single byte character (stray continuation bytes included)
            finish      = 1'b1;
            finish_code = {8'b0, i_byte};
        end

        // character complete: count it, emit unless sizing
        if (finish) begin
            n_partial = '0;
            if (sizing) begin
                if (r_count != '1) begin
                    n_count = r_count + 1'b1;
                end
            end else begin
                n_count  = r_count + 1'b1;
                res.has  = 1'b1;
                res.kind = KIND_UNIT;
                res.code = finish_code;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_left    <= '0;
            r_count   <= '0;
            r_discard <= 1'b0;
        end else if (i_fire) begin
            r_partial <= n_partial;
            r_left    <= n_left;
            r_count   <= n_count;
            r_discard <= n_discard;
        end
    end

    assign o_result = res;

endmodule

// ===== sv/utf8u_out_stage.sv =====
// ----------------------------------------------------------------------------
// utf8u_out_stage
// Result register and step control: a held byte is processed when it
// yields no result or when the result register is free.
// ----------------------------------------------------------------------------
module utf8u_out_stage import utf8u_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  t_result      i_result,
    output logic         o_fire,
    utf8u_unit_if.source o_res
);

    logic               r_valid;
    t_kind              r_kind;
    logic [UNIT_W-1:0]  r_code;
    logic [TOTAL_W-1:0] r_total;

    assign o_fire = i_valid && (!i_result.has || !r_valid || o_res.ready);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_fire && i_result.has) begin
            r_valid <= 1'b1;
            r_kind  <= i_result.kind;
            r_code  <= i_result.code;
            r_total <= i_result.total;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_res.valid     = r_valid;
    assign o_res.kind      = r_kind;
    assign o_res.code_unit = r_code;
    assign o_res.total     = r_total;

endmodule

// ===== sv/utf8u_checker.sv =====
// ----------------------------------------------------------------------------
// utf8u_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8u_checker import utf8u_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         out_kind,
    input logic [UNIT_W-1:0]  out_code,
    input logic [TOTAL_W-1:0] out_total,
    input logic               pready
);

    // result register is empty right after reset
    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !out_valid, "result valid after reset")

    // a stalled result is held
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_code) && $stable(out_total), "stalled result changed")

    // only defined kinds, with unused fields zero
    `ASSERT_CLK(a_kind, i_clk, i_rst_n, out_valid |-> (out_kind == KIND_UNIT && out_total == '0) || ((out_kind == KIND_END || out_kind == KIND_FULL) && out_code == '0), "bad result encoding")

    // capacity report never exceeds the 16-bit count, and pready is high with it
    `ASSERT_CLK(a_full_total, i_clk, i_rst_n, out_valid && out_kind == KIND_FULL |-> out_total[TOTAL_W-1] == 1'b0 && pready, "capacity total out of range")

endmodule

bind utf8_to_ucs2_stream_top utf8u_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .out_valid (o_res.valid),
    .out_ready (o_res.ready),
    .out_kind  (o_res.kind),
    .out_code  (o_res.code_unit),
    .out_total (o_res.total),
    .pready    (pready)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 to UCS-2 stream decoder. A driver feeds
// bytes from a queue over the byte channel. Each accepted byte runs through
// a decoder model that queues the result it should cause. A monitor checks
// every result transaction against that queue. Capacity is set over APB
// between phases. The phases cover directed strings, random well-formed and
// broken strings under several idle/stall patterns, and a long receiver
// hold-off.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8u_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int CFG_SETTLE = 8;
    localparam int HOLD_CYCLES = 400;
    localparam logic [APB_ADDR_W-1:0] CAP_ADDR = APB_ADDR_W'(4 * int'(REG_CAPACITY));

    // one expected result transaction
    typedef struct {
        t_kind              kind;
        logic [UNIT_W-1:0]  code_unit;
        logic [TOTAL_W-1:0] total;
    } t_unit_expect;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    utf8u_byte_if byte_ch ();
    utf8u_unit_if unit_ch ();

    utf8_to_ucs2_stream_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_byte  (byte_ch),
        .o_res   (unit_ch)
    );

    // bytes waiting to be sent, and results the decoder model predicts
    logic [BYTE_W-1:0] byte_q[$];
    t_unit_expect      expected_units[$];

    // decoder model state
    logic [CAP_W-1:0]  cap_m;
    logic [30:0]       code_m;
    logic [LEFT_W-1:0] left_m;
    logic [UNIT_W-1:0] count_m;
    logic              dropping_m;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int hold_seen;
    int hold_left;
    int fail_count;
    int cycle_count;

    // clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // decoder model: one accepted byte, at most one result
    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        t_unit_expect e;
        bit           has;
        bit           done_char;
        has = 0;
        done_char = 0;
        e.kind = KIND_UNIT;
        e.code_unit = '0;
        e.total = '0;
        if (b == '0) begin
            if (!dropping_m) begin
                has = 1;
                e.kind = KIND_END;
                e.total = (cap_m == 0) ? {count_m, 1'b0} : {1'b0, count_m};
            end
            code_m = '0;
            left_m = '0;
            count_m = '0;
            dropping_m = 1'b0;
        end else if (dropping_m) begin
            has = 0;
        end else if (left_m != 0) begin
            // continuation: low six bits, never checked
            code_m = {code_m[24:0], b[5:0]};
            left_m = left_m - 1'b1;
            done_char = (left_m == 0);
        end else if (cap_m != 0 && count_m >= cap_m) begin
            dropping_m = 1'b1;
            has = 1;
            e.kind = KIND_FULL;
            e.total = {1'b0, count_m};
        end else if (b >= LEAD6) begin
            code_m = 31'(b[0]);
            left_m = 3'd5;
        end else if (b >= LEAD5) begin
            code_m = 31'(b[1:0]);
            left_m = 3'd4;
        end else if (b >= LEAD4) begin
            code_m = 31'(b[2:0]);
            left_m = 3'd3;
        end else if (b >= LEAD3) begin
            code_m = 31'(b[3:0]);
            left_m = 3'd2;
        end else if (b >= LEAD2) begin
            code_m = 31'(b[4:0]);
            left_m = 3'd1;
        end else begin
            code_m = 31'(b);
            done_char = 1;
        end

        // finished character: counted, and given out unless sizing
        if (done_char) begin
            if (cap_m == 0) begin
                if (count_m != '1)
                    count_m = count_m + 1'b1;
            end else begin
                count_m = count_m + 1'b1;
                has = 1;
                e.kind = KIND_UNIT;
                e.code_unit = code_m[UNIT_W-1:0];
            end
            code_m = '0;
        end

        if (has)
            expected_units.push_back(e);
    endfunction

    // byte driver
    always @(posedge i_clk) begin : drive
        logic              nv;
        logic [BYTE_W-1:0] nb;
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
            byte_ch.in_byte <= '0;
        end else begin
            nv = byte_ch.valid;
            nb = byte_ch.in_byte;
            if (byte_ch.valid && byte_ch.ready) begin
                decode_byte(byte_ch.in_byte);
                nv = 1'b0;
            end
            if (!nv && byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nb = byte_q.pop_front();
                nv = 1'b1;
            end
            byte_ch.valid <= nv;
            byte_ch.in_byte <= nb;
        end
    end

    // long receiver hold-off, counted in cycles on request
    always @(posedge i_clk) begin : hold_count
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin : watch
        t_unit_expect e;
        logic         nr;
        if (!i_rst_n) begin
            unit_ch.ready <= 1'b0;
        end else begin
            if (unit_ch.valid && unit_ch.ready) begin
                if (expected_units.size() == 0) begin
                    $error("unexpected result: kind %0d code_unit %0h total %0d",
                           unit_ch.kind, unit_ch.code_unit, unit_ch.total);
                    fail_count++;
                end else begin
                    e = expected_units.pop_front();
                    if (unit_ch.kind !== e.kind) begin
                        $error("kind: expected %0d, got %0d", e.kind, unit_ch.kind);
                        fail_count++;
                    end
                    if (unit_ch.code_unit !== e.code_unit) begin
                        $error("code_unit: expected %0h, got %0h",
                               e.code_unit, unit_ch.code_unit);
                        fail_count++;
                    end
                    if (unit_ch.total !== e.total) begin
                        $error("total: expected %0d, got %0d", e.total, unit_ch.total);
                        fail_count++;
                    end
                end
            end
            // hold off while the long stall runs, else random stalls
            if (hold_left > 0)
                nr = 1'b0;
            else
                nr = ($urandom_range(99) >= recv_stall_pct);
            unit_ch.ready <= nr;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // wait until every byte is taken and every result has come back
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (byte_q.size() != 0 || byte_ch.valid || expected_units.size() != 0);
    endtask

    // APB write of the capacity register while the block is idle
    task automatic set_capacity(input logic [CAP_W-1:0] value);
        wait_idle();
        repeat (CFG_SETTLE) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAP_ADDR;
        pwdata <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        cap_m = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // random string: mostly well-formed characters, some stray and cut ones
    task automatic queue_random_string(input int max_chars);
        int n;
        int len;
        int r;
        n = $urandom_range(max_chars);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                byte_q.push_back(BYTE_W'($urandom_range(8'hBF, 8'h80)));
                continue;
            end
            r = $urandom_range(99);
            len = (r < 35) ? 1 : (r < 55) ? 2 : (r < 70) ? 3 : (r < 82) ? 4 :
                  (r < 91) ? 5 : 6;
            case (len)
                1: byte_q.push_back(BYTE_W'($urandom_range(8'h7F, 8'h01)));
                2: byte_q.push_back(BYTE_W'($urandom_range(8'hDF, 8'hC0)));
                3: byte_q.push_back(BYTE_W'($urandom_range(8'hEF, 8'hE0)));
                4: byte_q.push_back(BYTE_W'($urandom_range(8'hF7, 8'hF0)));
                5: byte_q.push_back(BYTE_W'($urandom_range(8'hFB, 8'hF8)));
                default: byte_q.push_back(BYTE_W'($urandom_range(8'hFF, 8'hFC)));
            endcase
            for (int k = 1; k < len; k++) begin
                // character cut off by the terminator
                if ($urandom_range(29) == 0) begin
                    i = n;
                    break;
                end
                if ($urandom_range(9) == 0)
                    byte_q.push_back(BYTE_W'($urandom_range(8'hFF, 8'h01)));
                else
                    byte_q.push_back(BYTE_W'($urandom_range(8'hBF, 8'h80)));
            end
        end
        byte_q.push_back('0);
    endtask

    // raw noise, terminator included at random
    task automatic queue_noise(input int count);
        for (int i = 0; i < count; i++)
            byte_q.push_back(BYTE_W'($urandom_range(8'hFF, 8'h00)));
        byte_q.push_back('0);
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int send_pct,
                             input int recv_pct, input int strings, input bit hold);
        set_capacity(cap);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        if (hold)
            hold_req++;
        for (int s = 0; s < strings; s++) begin
            if ($urandom_range(9) == 0)
                queue_noise($urandom_range(12, 1));
            else
                queue_random_string(6);
        end
    endtask

    // stimulus
    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        byte_ch.valid = 1'b0;
        byte_ch.in_byte = '0;
        unit_ch.ready = 1'b0;
        cap_m = '0;
        code_m = '0;
        left_m = '0;
        count_m = '0;
        dropping_m = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        fail_count = 0;
        cycle_count = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one- to three-, five- and six-byte leads, strays, capacity reached, cut-off char
        set_capacity(16'd3);
        byte_q = {byte_q, 8'h00, 8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0,
                  8'h41, 8'h00};
        byte_q = {byte_q, 8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
                  8'hF8, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'hF7, 8'h00};
        // mode change mid-string keeps the count
        byte_q = {byte_q, 8'h41, 8'hC3};
        set_capacity(16'd0);
        byte_q = {byte_q, 8'hA9, 8'h00};
        // sizing mode: stray byte, unchecked continuation, cut-off char
        byte_q = {byte_q, 8'h80, 8'hC0, 8'hFF, 8'hE0, 8'h00};
        // discarding goes on to the terminator after sizing is selected
        set_capacity(16'd1);
        byte_q = {byte_q, 8'h41, 8'h42};
        set_capacity(16'd0);
        byte_q = {byte_q, 8'h43, 8'h00, 8'h00};

        // random phases over capacity settings and idle patterns
        run_phase(16'hFFFF, 0, 0, 8, 0);
        run_phase(16'd0, 69, 0, 8, 0);
        run_phase(16'd2, 0, 69, 8, 0);
        run_phase(CAP_W'($urandom_range(12, 1)), 12, 12, 8, 0);
        run_phase(16'hFFFF, 0, 0, 10, 1);
        run_phase(16'd1, 69, 69, 6, 0);
        run_phase(CAP_W'($urandom_range(6, 3)), 0, 0, 8, 0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_units.size() != 0) begin
            $error("%0d expected results never arrived", expected_units.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
